// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the pattern scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, held off while reset is low.
`define UWPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the rising clock edge that also checks during reset.
`define UWPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/uwps_pkg.sv =====
// Types and constants shared by the wildcard pattern scanner and its checker.
`timescale 1ns / 1ps

package uwps_pkg;

    // Fixed widths of the beats and registers
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 40;
    localparam int OFFSET_OUT_W = 32;
    localparam int COUNT_W      = 2;
    localparam int LEN_W        = 6;
    localparam int WILD_W       = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int PAT_WORDS    = 4;
    localparam int STORED_BYTES = 32;
    localparam int RES_DEPTH    = 3;

    // Outcome reported on the last byte of a region
    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_AMBIGUOUS = 2'd2,
        ST_INVALID   = 2'd3
    } t_scan_status;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LENGTH = 3'd0,
        REG_WILD   = 3'd1,
        REG_PAT0   = 3'd2,
        REG_PAT1   = 3'd3,
        REG_PAT2   = 3'd4,
        REG_PAT3   = 3'd5
    } t_cfg_reg;

    // One result, status in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0]      count;
        logic [OFFSET_OUT_W-1:0] offset;
        t_scan_status            status;
    } t_result;

endpackage

// ===== hdl/unique_wildcard_pattern_scan.sv =====
// Wildcard byte pattern scanner: top level.
`timescale 1ns / 1ps
//
// Usage
//   Bytes of a region arrive on the slave stream (tdata = data byte, tlast = last
//   byte of the region). The configured pattern is compared against the most
//   recent pattern-length bytes after every beat; wildcard bytes match anything.
//   On the beat with tlast one result leaves on the master stream: status,
//   offset of the unique match and match count. Other beats give no result.
//   Configuration is written through the plain write port while the stream is
//   idle; it applies to bytes accepted from the following cycle on.
// Timing
//   One byte per cycle sustained while tready is high. A byte is shifted into the
//   window on the accepting edge, compared against the aligned pattern on the next
//   edge; the result of a last beat enters the result queue on that same edge.
//   A three-entry result queue parts the two sides: a stalled receiver only
//   holds off input once the queue and the byte being compared could fill it.
// Reset
//   Synchronous, active low: configuration, counters and queue are cleared;
//   tready stays low in the first cycle after reset is released.

module unique_wildcard_pattern_scan #(
    parameter int MAX_PATTERN_BYTES = 32,
    parameter int OFFSET_BITS       = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream: [7:0] data_byte
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [uwps_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic                                i_s_tlast,
    // master stream: [1:0] scan_status, [33:2] match_offset, [35:34] match_count
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [uwps_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [uwps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [uwps_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import uwps_pkg::*;

    localparam int ACT_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam logic [OFFSET_BITS-1:0] COUNT_TOP = {OFFSET_BITS{1'b1}};

    // Configuration registers
    logic [LEN_W-1:0]                    r_len;
    logic [WILD_W-1:0]                   r_wild;
    logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] r_pat;
    logic [PAT_WORDS*CFG_DATA_W-1:0]     w_pat_flat;

    // Aligned pattern, rebuilt from the configuration every cycle
    logic [ACT_W-1:0]             n_act, r_act;
    logic [MAX_PATTERN_BYTES-1:0] n_care, r_care;
    logic [7:0]                   n_want [MAX_PATTERN_BYTES];
    logic [7:0]                   r_want [MAX_PATTERN_BYTES];

    // Input side
    logic                   r_run;
    logic                   w_accept;
    logic [7:0]             r_window [MAX_PATTERN_BYTES];
    logic [OFFSET_BITS-1:0] r_seen, n_seen;

    // Compare stage
    logic                         r_p_valid;
    logic                         r_p_last;
    logic [OFFSET_BITS-1:0]       r_p_seen;
    logic [MAX_PATTERN_BYTES-1:0] w_ok;
    logic                         w_match;
    logic [COUNT_W-1:0]           r_hits, n_hits;
    logic [OFFSET_BITS-1:0]       r_first, n_first;
    t_result                      w_result;

    // Result queue
    t_result    r_res [RES_DEPTH];
    logic [1:0] r_wr_ptr, r_rd_ptr;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_wild <= '0;
            r_pat  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_LENGTH: r_len    <= i_cfg_wdata[LEN_W-1:0];
                REG_WILD:   r_wild   <= i_cfg_wdata[WILD_W-1:0];
                REG_PAT0:   r_pat[0] <= i_cfg_wdata;
                REG_PAT1:   r_pat[1] <= i_cfg_wdata;
                REG_PAT2:   r_pat[2] <= i_cfg_wdata;
                REG_PAT3:   r_pat[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pattern words as one byte-addressed vector, byte 0 lowest
    assign w_pat_flat = r_pat;

    // Active length, clipped to the window depth
    always_comb begin
        if (int'(r_len) > MAX_PATTERN_BYTES) begin
            n_act = ACT_W'(MAX_PATTERN_BYTES);
        end else begin
            n_act = ACT_W'(r_len);
        end
    end

    // Pattern byte i lines up with window entry len-1-i; bytes past storage are wildcards
    always_comb begin
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            n_care[j] = 1'b0;
            n_want[j] = 8'h00;
            if (j < int'(n_act) && (int'(n_act) - 1 - j) < STORED_BYTES) begin
                n_care[j] = !r_wild[5'(int'(n_act) - 1 - j)];
                n_want[j] = w_pat_flat[8 * (int'(n_act) - 1 - j) +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= '0;
            r_care <= '0;
        end else begin
            r_act  <= n_act;
            r_care <= n_care;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            r_want[j] <= n_want[j];
        end
    end

    // Input handshake: hold off when queued plus pending results could fill the queue
    assign o_s_tready = r_run && ((3'(r_cnt) + 3'(r_p_valid && r_p_last)) < 3'(RES_DEPTH));
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Saturating byte count of the region
    assign n_seen = (r_seen == COUNT_TOP) ? r_seen : r_seen + OFFSET_BITS'(1);

    // Byte window, newest at entry 0; stale entries are never read as a match
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_window[0] <= i_s_tdata;
            for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
                r_window[k] <= r_window[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_seen    <= '0;
            r_p_valid <= 1'b0;
            r_p_last  <= 1'b0;
            r_p_seen  <= '0;
        end else begin
            r_run     <= 1'b1;
            r_p_valid <= w_accept;
            if (w_accept) begin
                r_p_last <= i_s_tlast;
                r_p_seen <= n_seen;
                r_seen   <= i_s_tlast ? '0 : n_seen;
            end
        end
    end

    // Parallel byte compare against the aligned pattern
    always_comb begin
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            w_ok[j] = !r_care[j] || (r_window[j] == r_want[j]);
        end
    end

    assign w_match = r_p_valid && (r_act != '0) &&
                     (r_p_seen >= OFFSET_BITS'(r_act)) && (&w_ok);

    // Match bookkeeping: count to two, keep the first start offset
    always_comb begin
        n_hits  = r_hits;
        n_first = r_first;
        if (w_match) begin
            if (r_hits == 2'd0) begin
                n_first = r_p_seen - OFFSET_BITS'(r_act);
            end
            if (r_hits != 2'd2) begin
                n_hits = r_hits + 2'd1;
            end
        end
    end

    // Outcome of the region
    always_comb begin
        w_result.status = ST_NOT_FOUND;
        w_result.offset = '0;
        w_result.count  = 2'd0;
        if (r_act == '0) begin
            w_result.status = ST_INVALID;
        end else begin
            unique case (n_hits)
                2'd0: w_result.status = ST_NOT_FOUND;
                2'd1: begin
                    w_result.status = ST_FOUND;
                    w_result.offset = OFFSET_OUT_W'(n_first);
                    w_result.count  = 2'd1;
                end
                default: begin
                    w_result.status = ST_AMBIGUOUS;
                    w_result.count  = 2'd2;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits  <= '0;
            r_first <= '0;
        end else if (r_p_valid) begin
            if (r_p_last) begin
                r_hits  <= '0;
                r_first <= '0;
            end else begin
                r_hits  <= n_hits;
                r_first <= n_first;
            end
        end
    end

    // Result queue
    assign w_push = r_p_valid && r_p_last;
    assign w_pop  = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_res[r_wr_ptr] <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == 2'(RES_DEPTH - 1)) ? 2'd0 : r_wr_ptr + 2'd1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == 2'(RES_DEPTH - 1)) ? 2'd0 : r_rd_ptr + 2'd1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = OUT_TDATA_W'(r_res[r_rd_ptr]);

endmodule

// ===== hdl/uwps_checker.sv =====
// Port-level checker for the wildcard pattern scanner, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uwps_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [uwps_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import uwps_pkg::*;

    // Fields of the result beat on the master side
    logic [1:0]              w_status;
    logic [OFFSET_OUT_W-1:0] w_offset;
    logic [COUNT_W-1:0]      w_count;
    logic [COUNT_W-1:0]      w_count_want;

    assign w_status = o_m_tdata[1:0];
    assign w_offset = o_m_tdata[33:2];
    assign w_count  = o_m_tdata[35:34];

    // Count that each status carries
    always_comb begin
        unique case (w_status)
            ST_FOUND:     w_count_want = 2'd1;
            ST_AMBIGUOUS: w_count_want = 2'd2;
            default:      w_count_want = 2'd0;
        endcase
    end

    // A stalled result beat keeps its payload
    `UWPS_ASSERT(a_stall_hold, i_clk, i_rst_n,
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata),
        "result changed while stalled")

    // Offset is only reported for a unique match
    `UWPS_ASSERT(a_offset_found, i_clk, i_rst_n,
        o_m_tvalid |-> (w_status == ST_FOUND) || (w_offset == '0),
        "offset without unique match")

    // Count agrees with status
    `UWPS_ASSERT(a_count_status, i_clk, i_rst_n,
        o_m_tvalid |-> (w_count == w_count_want),
        "count does not fit status")

    // Both sides are quiet after a reset edge
    `UWPS_ASSERT_ALWAYS(a_reset_quiet, i_clk,
        !i_rst_n |=> !o_m_tvalid && !o_s_tready,
        "channel active after reset")

endmodule

bind unique_wildcard_pattern_scan uwps_checker u_uwps_checker (.*);
